>>> src/cesp_pkg.sv
package cesp_pkg;

  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_M    = 8'h6D;  // 'm'
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [7:0] CH_H    = 8'h48;  // 'H'
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_7    = 8'h37;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam logic [1:0] ACT_PRINT  = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_COLUMN = 2'd2;
  localparam logic [1:0] ACT_ROW    = 2'd3;

  localparam logic REG_BASE_COLOR  = 1'b0;
  localparam logic REG_COLOR_TABLE = 1'b1;

  localparam logic [7:0]  BASE_COLOR_RST  = 8'd7;
  localparam logic [31:0] COLOR_TABLE_RST = 32'h7654_3210;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  chr;
    logic [7:0]  color;
    logic [15:0] position;
    logic [3:0]  screen;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [1:0]         cnt;
  } batch_t;

endpackage

>>> src/cesp_parser.sv
module cesp_parser import cesp_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_i,
  input  logic        first_i,
  input  logic [7:0]  ch_i,
  input  logic [3:0]  screen_i,
  input  logic [7:0]  base_color_i,
  input  logic [31:0] color_table_i,
  output batch_t      batch_o
);

  localparam int AW = POSITION_BITS;
  localparam logic [AW-1:0] MAXV = {AW{1'b1}};

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_SKIP  = 3'd1;
  localparam logic [2:0] MODE_HOLD0 = 3'd2;
  localparam logic [2:0] MODE_HOLD1 = 3'd3;
  localparam logic [2:0] MODE_HOLD2 = 3'd4;
  localparam logic [2:0] MODE_NUM   = 3'd5;

  logic [2:0]    mode_r, mode_nxt;
  logic [7:0]    held0_r, held0_nxt;
  logic [7:0]    held1_r, held1_nxt;
  logic [7:0]    color_r, color_nxt;
  logic [AW-1:0] acc_r, acc_nxt;

  function automatic logic [7:0] digit_color(input logic [7:0] d, input logic [31:0] tbl,
                                             input logic [7:0] dflt);
    logic [2:0] idx;
    idx = 3'(d - CH_0);
    if (d >= CH_0 && d <= CH_7) return {4'h0, tbl[{idx, 2'b00} +: 4]};
    return dflt;
  endfunction

  function automatic logic [AW-1:0] add_digit(input logic [AW-1:0] acc, input logic [7:0] b);
    logic [AW+3:0] v;
    logic [3:0]    dig;
    dig = 4'(b - CH_0);
    v = ({4'h0, acc} << 3) + ({4'h0, acc} << 1) + (AW+4)'(dig);
    return (v > {4'h0, MAXV}) ? MAXV : v[AW-1:0];
  endfunction

  always_comb begin
    logic [7:0] seq [3];
    logic [1:0] nb;
    logic [1:0] n;
    logic [7:0] b;
    logic [7:0] dc;
    res_t       r;
    batch_t     bt;

    mode_nxt  = first_i ? MODE_IDLE : mode_r;
    color_nxt = first_i ? base_color_i : color_r;
    acc_nxt   = first_i ? '0 : acc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    seq[0] = ch_i;
    seq[1] = ch_i;
    seq[2] = ch_i;
    nb = 2'd1;
    n  = 2'd0;
    bt = '0;
    dc = digit_color(held1_r, color_table_i, base_color_i);

    // fourth byte after ESC decides: color sequence, or replay held bytes as a number
    if (mode_nxt == MODE_HOLD2) begin
      if (ch_i == CH_M) begin
        if (held0_r == CH_3) color_nxt = dc;
        else if (held0_r == CH_4) color_nxt = {dc[3:0], color_nxt[3:0]};
        mode_nxt = MODE_IDLE;
        nb = 2'd0;
      end else begin
        seq[0] = held0_r;
        seq[1] = held1_r;
        nb = 2'd3;
        mode_nxt = MODE_NUM;
        acc_nxt = '0;
      end
    end

    for (int i = 0; i < MAX_RES; i++) begin
      b = seq[i];
      r = '0;
      r.screen = screen_i;
      if (2'(i) < nb) begin
        case (mode_nxt)
          MODE_NUM: begin
            if (b >= CH_0 && b <= CH_9) begin
              acc_nxt = add_digit(acc_nxt, b);
            end else if (b == CH_SEMI) begin
              r.action = ACT_COLUMN;
              r.position = 16'(acc_nxt);
              if (n != 2'd3) begin
                bt.ent[n] = r;
                n = n + 2'd1;
              end
              acc_nxt = '0;
            end else begin
              if (b == CH_H) begin
                r.action = ACT_ROW;
                r.position = 16'(acc_nxt);
                if (n != 2'd3) begin
                  bt.ent[n] = r;
                  n = n + 2'd1;
                end
              end
              mode_nxt = MODE_IDLE;
              acc_nxt = '0;
            end
          end
          MODE_SKIP: mode_nxt = MODE_HOLD0;
          MODE_HOLD0: begin
            held0_nxt = b;
            mode_nxt = MODE_HOLD1;
          end
          MODE_HOLD1: begin
            held1_nxt = b;
            mode_nxt = MODE_HOLD2;
          end
          default: begin
            mode_nxt = MODE_IDLE;
            if (b == CH_ESC) begin
              mode_nxt = MODE_SKIP;
            end else begin
              if (b == CH_DEL) begin
                r.action = ACT_DELETE;
              end else begin
                r.action = ACT_PRINT;
                r.chr = b;
                r.color = color_nxt;
              end
              if (n != 2'd3) begin
                bt.ent[n] = r;
                n = n + 2'd1;
              end
            end
          end
        endcase
      end
    end

    case (n)
      2'd1: bt.ent[0].last = 1'b1;
      2'd2: bt.ent[1].last = 1'b1;
      2'd3: bt.ent[2].last = 1'b1;
      default: ;
    endcase
    bt.cnt = n;
    batch_o = bt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      color_r <= BASE_COLOR_RST;
      acc_r   <= '0;
    end else if (step_i) begin
      mode_r  <= mode_nxt;
      color_r <= color_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

  a_acc_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= MAXV)
    else $error("number accumulator above saturation limit");

  a_color_seq_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && !first_i && mode_r == MODE_HOLD2 && ch_i == CH_M |=> mode_r == MODE_IDLE)
    else $error("color sequence did not return parser to idle");

  a_color_seq_silent: assert property (@(posedge clk) disable iff (!rst_n)
    !first_i && mode_r == MODE_HOLD2 && ch_i == CH_M |-> batch_o.cnt == 2'd0)
    else $error("color sequence produced a command");

endmodule

>>> src/cesp_outq.sv
module cesp_outq import cesp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load_i,
  input  batch_t batch_i,
  input  logic   out_ready_i,
  output logic   can_load_o,
  output logic   out_valid_o,
  output res_t   head_o
);

  res_t [MAX_RES-1:0] ent_r;
  logic [1:0]         cnt_r;

  assign out_valid_o = (cnt_r != 2'd0);
  assign head_o      = ent_r[0];
  // refill in the same cycle the last pending beat leaves
  assign can_load_o  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load_i) begin
      cnt_r <= batch_i.cnt;
    end else if (out_valid_o && out_ready_i) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      ent_r <= batch_i.ent;
    end else if (out_valid_o && out_ready_i) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> can_load_o)
    else $error("batch loaded over pending results");

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_o |-> (head_o.last == (cnt_r == 2'd1)))
    else $error("last flag does not match queue depth");

  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(head_o))
    else $error("stalled output beat changed");

endmodule

>>> src/console_escape_sequence_parser.sv
// Console escape-sequence parser.
// Input channel (in_valid/in_ready): one console byte per beat with its
// write-start flag and target screen. Output channel (out_valid/out_ready):
// display commands (print, delete, set column, set row); out_last marks the
// final command caused by an input byte, and a byte may cause none.
// Configuration: APB-style write/read of the base color (0x0) and
// color_table (0x4); write only while no byte is in flight.
// An input beat passes the input register, then one pass of parse logic into
// the queue. Throughput: one byte per cycle while each byte gives at most one
// command and out_ready is high. A byte that gives k commands holds the output
// until all k are taken, drained by the single result port from a three-entry
// queue; input stalls meanwhile.
// The next byte enters the queue in the cycle the last pending command is taken.
// Reset: parser idle, color 7, registers to their defaults, queue empty.
// Receiver stall: commands hold on the output, the input register fills,
// then in_ready drops; nothing is lost or repeated.
module console_escape_sequence_parser import cesp_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_first_of_write,
  input  logic [7:0]  in_ch,
  input  logic [3:0]  in_screen_sel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_action,
  output logic [7:0]  out_char,
  output logic [7:0]  out_color,
  output logic [15:0] out_position,
  output logic [3:0]  out_screen,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  base_color_r;
  logic [31:0] color_table_r;
  logic        s1_valid_r;
  logic        s1_first_r;
  logic [7:0]  s1_ch_r;
  logic [3:0]  s1_screen_r;
  logic        can_load;
  logic        step;
  batch_t      batch;
  res_t        head;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_COLOR_TABLE) ? color_table_r : {24'h0, base_color_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_color_r  <= BASE_COLOR_RST;
      color_table_r <= COLOR_TABLE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BASE_COLOR) base_color_r <= pwdata[7:0];
      else color_table_r <= pwdata;
    end
  end

  assign step     = s1_valid_r && can_load;
  assign in_ready = !s1_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_first_r  <= in_first_of_write;
      s1_ch_r     <= in_ch;
      s1_screen_r <= in_screen_sel;
    end
  end

  cesp_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_i       (step),
    .first_i      (s1_first_r),
    .ch_i         (s1_ch_r),
    .screen_i     (s1_screen_r),
    .base_color_i (base_color_r),
    .color_table_i(color_table_r),
    .batch_o      (batch)
  );

  cesp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (step),
    .batch_i    (batch),
    .out_ready_i(out_ready),
    .can_load_o (can_load),
    .out_valid_o(out_valid),
    .head_o     (head)
  );

  assign out_action   = head.action;
  assign out_char     = head.chr;
  assign out_color    = head.color;
  assign out_position = head.position;
  assign out_screen   = head.screen;
  assign out_last     = head.last;

endmodule
